// ----- sv/udrrb_pkg.sv -----
// Shared types and codes for the serial receive ring buffer.
package udrrb_pkg;

    // Field widths fixed by the interface.
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_LEN_W  = 7;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 7;

    // Request codes.
    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_IDLE  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_FLUSH = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ENABLE = 1'b1;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [BYTE_W-1:0]    rx_byte;
        logic [MAX_LEN_W-1:0] max_len;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last;
        logic               status;
        logic [COUNT_W-1:0] bytes_read;
        logic               data_pending;
        logic               notify;
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic stream;
        logic red_step;
        logic red_last;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stream_go;
        logic last_byte;
    } dp_status_t;

endpackage

// ----- sv/udrrb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module udrrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/udrrb_ctrl.sv -----
// Controller state machine: idle, read streaming and position reduction.
module udrrb_ctrl
    import udrrb_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  dp_status_t           status,
    output ctrl_cmd_t            cmd,
    output logic [((($clog2(RING_DEPTH)) > 1) ? $clog2($clog2(RING_DEPTH)) : 1)-1:0] red_idx,
    output logic                 busy
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int IW = (PW > 1) ? $clog2(PW) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ   = 2'd1;
    localparam logic [1:0] ST_REDUCE = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          accept;
    logic          red_restart;

    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign red_restart = cfg_we && (state_reg != ST_READ)
                         && ((state_reg == ST_REDUCE) || (cfg_index == REG_BUFFER_SIZE));

    // Issue commands
    always_comb
    begin
        cmd.accept   = accept;
        cmd.stream   = (state_reg == ST_READ);
        cmd.red_step = (state_reg == ST_REDUCE) && !cfg_we;
        cmd.red_last = (state_reg == ST_REDUCE) && !cfg_we && (idx_reg == '0);
    end

    assign red_idx = idx_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (red_restart)
                begin
                    state_next = ST_REDUCE;
                    idx_next   = IW'(PW - 1);
                end
                else if (accept && status.stream_go)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (status.last_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REDUCE:
            begin
                if (red_restart)
                begin
                    idx_next = IW'(PW - 1);
                end
                else if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- sv/udrrb_dp.sv -----
// Datapath: ring positions, pending flag, read stream and result register.
module udrrb_dp
    import udrrb_pkg::*;
#(
    parameter int RING_DEPTH = 1024,
    parameter int MAX_READ   = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  req_t                  request,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ctrl_cmd_t             cmd,
    input  logic [((($clog2(RING_DEPTH)) > 1) ? $clog2($clog2(RING_DEPTH)) : 1)-1:0] red_idx,
    output dp_status_t            status,
    output res_t                  result,
    output logic                  result_valid
);

    localparam int PW       = $clog2(RING_DEPTH);
    localparam int SW       = $clog2(RING_DEPTH + 1);
    localparam int TW       = PW + 1;
    localparam int CW       = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;
    localparam int AW       = (SW > MAX_LEN_W) ? SW : MAX_LEN_W;
    localparam int NW       = $clog2(MAX_READ + 1);
    localparam int IW       = (PW > 1) ? $clog2(PW) : 1;
    localparam int RST_SIZE = (RING_DEPTH < 1024) ? RING_DEPTH : 1024;

    // One restoring remainder step: shift in a bit, subtract size if it fits.
    function automatic logic [PW-1:0] rem_step(input logic [PW-1:0] rem, input logic b,
                                               input logic [TW-1:0] sz);
        logic [TW-1:0] t;
        t = {rem, b};
        if (t >= sz)
        begin
            t = t - sz;
        end
        return t[PW-1:0];
    endfunction

    logic [SW-1:0] size_reg, size_next;
    logic          en_reg, en_next;
    logic [PW-1:0] wp_raw_reg, wp_raw_next, hd_raw_reg, hd_raw_next, tl_raw_reg, tl_raw_next;
    logic [PW-1:0] wp_red_reg, wp_red_next, hd_red_reg, hd_red_next, tl_red_reg, tl_red_next;
    logic [PW-1:0] lane_wp_reg, lane_wp_next, lane_hd_reg, lane_hd_next;
    logic [PW-1:0] lane_tl_reg, lane_tl_next;
    logic          pending_reg, pending_next;
    logic [PW-1:0] rd_addr_reg, rd_addr_next;
    logic [NW-1:0] remain_reg, remain_next, count_reg, count_next;
    logic          strobe_reg, strobe_next, byte_sel_reg, byte_sel_next;
    res_t          res_reg, res_next;

    logic [TW-1:0]        size_tw;
    logic [TW-1:0]        wp_inc, rd_inc, tl_sum;
    logic [PW-1:0]        wp_wrap, rd_wrap, tl_adv;
    logic [AW-1:0]        avail, n_aw;
    logic [MAX_LEN_W-1:0] mlen_sat;
    logic [CW-1:0]        cfg_wide;
    logic [SW-1:0]        size_sat;
    logic [PW-1:0]        st_wp, st_hd, st_tl;
    logic                 ram_we;
    logic [BYTE_W-1:0]    ram_rdata;

    assign size_tw = TW'(size_reg);

    // Advance the write position with wrap
    assign wp_inc  = TW'(wp_red_reg) + 1'b1;
    assign wp_wrap = (wp_inc == size_tw) ? '0 : wp_inc[PW-1:0];

    // Advance the read address with wrap
    assign rd_inc  = TW'(rd_addr_reg) + 1'b1;
    assign rd_wrap = (rd_inc == size_tw) ? '0 : rd_inc[PW-1:0];

    // Count unread bytes and clip the read length
    assign avail = (hd_red_reg > tl_red_reg) ? (AW'(hd_red_reg) - AW'(tl_red_reg))
                 : (AW'(size_reg) - AW'(tl_red_reg) + AW'(hd_red_reg));
    assign mlen_sat = (request.max_len > MAX_LEN_W'(MAX_READ)) ? MAX_LEN_W'(MAX_READ)
                    : request.max_len;
    assign n_aw   = (AW'(mlen_sat) < avail) ? AW'(mlen_sat) : avail;
    assign tl_sum = TW'(tl_red_reg) + TW'(n_aw);
    assign tl_adv = (tl_sum >= size_tw) ? PW'(tl_sum - size_tw) : tl_sum[PW-1:0];

    // Saturate the ring size written by configuration
    assign cfg_wide = CW'(cfg_data);
    assign size_sat = (cfg_wide == '0) ? SW'(1)
                    : (cfg_wide > CW'(RING_DEPTH)) ? SW'(RING_DEPTH) : SW'(cfg_wide);

    // Reduction lanes, one bit per cycle unless a register write restarts them
    assign st_wp = rem_step(lane_wp_reg, wp_raw_reg[red_idx], size_tw);
    assign st_hd = rem_step(lane_hd_reg, hd_raw_reg[red_idx], size_tw);
    assign st_tl = rem_step(lane_tl_reg, tl_raw_reg[red_idx], size_tw);

    assign status.stream_go = (request.req_type == REQ_READ) && pending_reg
                              && (mlen_sat != '0);
    assign status.last_byte = (remain_reg == NW'(1));

    always_comb
    begin
        size_next     = size_reg;
        en_next       = en_reg;
        wp_raw_next   = wp_raw_reg;
        hd_raw_next   = hd_raw_reg;
        tl_raw_next   = tl_raw_reg;
        wp_red_next   = wp_red_reg;
        hd_red_next   = hd_red_reg;
        tl_red_next   = tl_red_reg;
        lane_wp_next  = lane_wp_reg;
        lane_hd_next  = lane_hd_reg;
        lane_tl_next  = lane_tl_reg;
        pending_next  = pending_reg;
        rd_addr_next  = rd_addr_reg;
        remain_next   = remain_reg;
        count_next    = count_reg;
        strobe_next   = 1'b0;
        byte_sel_next = 1'b0;
        res_next      = '0;
        ram_we        = 1'b0;

        // Configuration writes; any write restarts the reduction lanes
        if (cfg_we)
        begin
            lane_wp_next = '0;
            lane_hd_next = '0;
            lane_tl_next = '0;
            if (cfg_index == REG_BUFFER_SIZE)
            begin
                size_next = size_sat;
            end
            else
            begin
                en_next = cfg_data[0];
                if (cfg_data[0] && !en_reg)
                begin
                    wp_raw_next = '0;
                    wp_red_next = '0;
                end
            end
        end
        else if (cmd.red_step)
        begin
            if (cmd.red_last)
            begin
                wp_red_next = st_wp;
                hd_red_next = st_hd;
                tl_red_next = st_tl;
            end
            else
            begin
                lane_wp_next = st_wp;
                lane_hd_next = st_hd;
                lane_tl_next = st_tl;
            end
        end

        // Start a transaction
        if (cmd.accept)
        begin
            unique case (request.req_type)
                REQ_BYTE:
                begin
                    if (en_reg)
                    begin
                        ram_we      = 1'b1;
                        wp_raw_next = wp_wrap;
                        wp_red_next = wp_wrap;
                    end
                end
                REQ_IDLE:
                begin
                    if (en_reg)
                    begin
                        hd_raw_next           = wp_red_reg;
                        hd_red_next           = wp_red_reg;
                        pending_next          = 1'b1;
                        strobe_next           = 1'b1;
                        res_next.last         = 1'b1;
                        res_next.data_pending = 1'b1;
                        res_next.notify       = 1'b1;
                    end
                end
                REQ_FLUSH:
                begin
                    tl_raw_next   = hd_red_reg;
                    tl_red_next   = hd_red_reg;
                    pending_next  = 1'b0;
                    strobe_next   = 1'b1;
                    res_next.last = 1'b1;
                end
                REQ_READ:
                begin
                    if (!pending_reg)
                    begin
                        strobe_next     = 1'b1;
                        res_next.last   = 1'b1;
                        res_next.status = 1'b1;
                    end
                    else if (mlen_sat == '0)
                    begin
                        strobe_next           = 1'b1;
                        res_next.last         = 1'b1;
                        res_next.data_pending = pending_reg;
                    end
                    else
                    begin
                        rd_addr_next = tl_red_reg;
                        remain_next  = NW'(n_aw);
                        count_next   = NW'(n_aw);
                        tl_raw_next  = tl_adv;
                        tl_red_next  = tl_adv;
                        pending_next = (n_aw != avail);
                    end
                end
                default:
                begin
                    strobe_next = 1'b0;
                end
            endcase
        end

        // Stream one ring byte per cycle
        if (cmd.stream)
        begin
            rd_addr_next          = rd_wrap;
            remain_next           = remain_reg - 1'b1;
            strobe_next           = 1'b1;
            byte_sel_next         = 1'b1;
            res_next.byte_valid   = 1'b1;
            res_next.last         = status.last_byte;
            res_next.bytes_read   = status.last_byte ? COUNT_W'(count_reg) : '0;
            res_next.data_pending = pending_reg;
        end
    end

    // Control and position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg     <= SW'(RST_SIZE);
            en_reg       <= 1'b0;
            wp_raw_reg   <= '0;
            hd_raw_reg   <= '0;
            tl_raw_reg   <= '0;
            wp_red_reg   <= '0;
            hd_red_reg   <= '0;
            tl_red_reg   <= '0;
            pending_reg  <= 1'b0;
            remain_reg   <= '0;
            strobe_reg   <= 1'b0;
            byte_sel_reg <= 1'b0;
        end
        else
        begin
            size_reg     <= size_next;
            en_reg       <= en_next;
            wp_raw_reg   <= wp_raw_next;
            hd_raw_reg   <= hd_raw_next;
            tl_raw_reg   <= tl_raw_next;
            wp_red_reg   <= wp_red_next;
            hd_red_reg   <= hd_red_next;
            tl_red_reg   <= tl_red_next;
            pending_reg  <= pending_next;
            remain_reg   <= remain_next;
            strobe_reg   <= strobe_next;
            byte_sel_reg <= byte_sel_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lane_wp_reg <= lane_wp_next;
        lane_hd_reg <= lane_hd_next;
        lane_tl_reg <= lane_tl_next;
        rd_addr_reg <= rd_addr_next;
        count_reg   <= count_next;
        res_reg     <= res_next;
    end

    udrrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_red_reg),
        .wdata (request.rx_byte),
        .re    (cmd.stream),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // Drive the result, taking the byte straight from the RAM read register
    always_comb
    begin
        result          = res_reg;
        result.out_byte = byte_sel_reg ? ram_rdata : '0;
    end

    assign result_valid = strobe_reg;

endmodule

// ----- sv/uart_dma_ring_receive_buffer.sv -----
// Top level of the serial receive ring buffer with idle-line framing.
// Usage: a request is taken at a clock edge where start is high and busy is low.
// Request kinds: received byte, idle-line event, read and flush.
// Results come out on result with result_valid high for exactly one cycle;
// the receiver cannot stall them, so every strobe is a finished transaction.
// Latency: a non-read result appears the cycle after the request is taken.
// A read of n bytes passes the state and read address registers and then the RAM read
// register before its first byte shows, then streams one byte per cycle with busy high
// until its last byte; the single RAM read port with registered data sets this one-byte-per-cycle rate.
// Received bytes and idle events leave busy low.
// Configuration: cfg_we, cfg_index and cfg_data write buffer_size (index 0)
// or receive_enable (index 1) in the same cycle, with no handshake back.
// A buffer_size write outside a read stream starts a reduction of the ring positions
// modulo the new size, one bit per cycle with busy high; any write during it restarts it.
// Reset clears all positions and the pending flag, sets buffer_size to 1024
// (held to RING_DEPTH) and receive_enable to 0; ring contents are not cleared.
module uart_dma_ring_receive_buffer
    import udrrb_pkg::*;
#(
    parameter int RING_DEPTH = 1024,
    parameter int MAX_READ   = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  request,
    output res_t                  result,
    output logic                  result_valid,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int IW = (PW > 1) ? $clog2(PW) : 1;

    ctrl_cmd_t     cmd;
    dp_status_t    dp_status;
    logic [IW-1:0] red_idx;

    udrrb_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .status    (dp_status),
        .cmd       (cmd),
        .red_idx   (red_idx),
        .busy      (busy)
    );

    udrrb_dp #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .red_idx      (red_idx),
        .status       (dp_status),
        .result       (result),
        .result_valid (result_valid)
    );

    // A read stream runs without gaps until its last byte
    a_stream_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid && result.byte_valid)
        else $error("read stream broke before its last byte");

    // The last byte of a read carries a nonzero count
    a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.byte_valid && result.last |-> result.bytes_read != '0)
        else $error("last read byte without a byte count");

    // An idle-line notification always leaves data pending
    a_notify_pending: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.notify |-> result.data_pending && result.last)
        else $error("notify without pending data");

    // An empty read returns no data and nothing pending
    a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |-> !result.data_pending && !result.byte_valid)
        else $error("empty status on a read that returned data");

    // Streaming keeps the block busy
    a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.stream |-> busy && !cmd.accept)
        else $error("request taken during a read stream");

endmodule

// ----- dv/uart_dma_ring_receive_buffer_test.sv -----
// Self-checking testbench for the serial receive ring buffer with idle-line framing.
module uart_dma_ring_receive_buffer_test;
    import udrrb_pkg::*;

    localparam int RING_DEPTH    = 1024;
    localparam int MAX_READ      = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 14;

    // One row of the directed plan: a register write or a request
    typedef struct packed {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        req_t                  rq;
        bit                    has_typed;
        res_t                  typed;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_t                  request;
    res_t                  result;
    logic                  result_valid;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the ring and its pointers
    logic [7:0]  ring_copy [RING_DEPTH];
    bit          ring_filled [RING_DEPTH];
    logic [9:0]  wr_ptr;
    logic [9:0]  head_ptr;
    logic [9:0]  tail_ptr;
    logic        frame_pending;
    logic [10:0] size_reg;
    logic        rx_on;

    res_t        expected_results [$];
    res_t        step_results [$];
    res_t        want;
    plan_row_t   directed_plan [$];

    int          phase_size [PHASE_COUNT] = '{1, 2047, 5, 1024, 16, 0, 64, 3, 100, 9};
    bit          phase_rx [PHASE_COUNT]   = '{1, 1, 1, 1, 1, 1, 0, 1, 1, 1};

    bit          steady;
    int          mismatch_count;
    int          items_sent;
    int          read_count;
    int          whole_ring_count;
    int          results_checked;
    int          stall_cycles;

    uart_dma_ring_receive_buffer #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_READ   (MAX_READ)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    // Ring length in use, held to 1 .. RING_DEPTH
    function automatic int ring_span();
        if (size_reg == 0)
        begin
            return 1;
        end
        if (size_reg > RING_DEPTH)
        begin
            return RING_DEPTH;
        end
        return int'(size_reg);
    endfunction

    // Unread bytes between tail and head; equal pointers mean a full ring
    function automatic int ring_avail();
        int span;
        int hd;
        int tl;
        span = ring_span();
        hd = int'(head_ptr) % span;
        tl = int'(tail_ptr) % span;
        return (hd > tl) ? (hd - tl) : (span - tl + hd);
    endfunction

    // Bytes a read of the given length takes while data is pending
    function automatic int take_count(input logic [6:0] len);
        int n;
        n = int'(len);
        if (n > MAX_READ)
        begin
            n = MAX_READ;
        end
        if (n > ring_avail())
        begin
            n = ring_avail();
        end
        return n;
    endfunction

    // A read is safe when every entry it would return was written before
    function automatic bit read_is_safe(input logic [6:0] len);
        int span;
        int tl;
        int n;
        int i;
        if (!frame_pending)
        begin
            return 1'b1;
        end
        span = ring_span();
        tl = int'(tail_ptr) % span;
        n = take_count(len);
        for (i = 0; i < n; i++)
        begin
            if (!ring_filled[(tl + i) % span])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Clear the shadow pointers and flags as reset does, and mark every ring entry unwritten
    task automatic reset_shadow();
        wr_ptr        = '0;
        head_ptr      = '0;
        tail_ptr      = '0;
        frame_pending = 1'b0;
        size_reg      = 11'd1024;
        rx_on         = 1'b0;
        foreach (ring_filled[i])
        begin
            ring_filled[i] = 1'b0;
            ring_copy[i]   = 8'h00;
        end
    endtask

    // Apply a register write to the shadow state
    task automatic shadow_config(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_BUFFER_SIZE)
        begin
            size_reg = val;
        end
        else
        begin
            if (val[0] && !rx_on)
            begin
                wr_ptr = '0;
            end
            rx_on = val[0];
        end
    endtask

    // Work out the results of one request and advance the shadow state
    task automatic predict_ring_request(input req_t rq);
        int   span;
        int   wp;
        int   hd;
        int   tl;
        int   avail;
        int   n;
        int   i;
        res_t r;
        step_results.delete();
        span = ring_span();
        wp = int'(wr_ptr) % span;
        hd = int'(head_ptr) % span;
        tl = int'(tail_ptr) % span;
        r = '0;
        r.last = 1'b1;
        case (rq.req_type)
            REQ_BYTE:
            begin
                if (rx_on)
                begin
                    ring_copy[wp]   = rq.rx_byte;
                    ring_filled[wp] = 1'b1;
                    wr_ptr = 10'((wp + 1) % span);
                end
            end
            REQ_IDLE:
            begin
                if (rx_on)
                begin
                    head_ptr = 10'(wp);
                    frame_pending = 1'b1;
                    r.data_pending = 1'b1;
                    r.notify = 1'b1;
                    step_results.push_back(r);
                end
            end
            REQ_FLUSH:
            begin
                tail_ptr = 10'(hd);
                frame_pending = 1'b0;
                step_results.push_back(r);
            end
            REQ_READ:
            begin
                read_count++;
                if (!frame_pending)
                begin
                    r.status = 1'b1;
                    step_results.push_back(r);
                end
                else
                begin
                    avail = ring_avail();
                    n = take_count(rq.max_len);
                    if (n == 0)
                    begin
                        r.data_pending = frame_pending;
                        step_results.push_back(r);
                    end
                    else
                    begin
                        if (hd == tl)
                        begin
                            whole_ring_count++;
                        end
                        if (n == avail)
                        begin
                            frame_pending = 1'b0;
                        end
                        for (i = 0; i < n; i++)
                        begin
                            r = '0;
                            r.out_byte     = ring_copy[(tl + i) % span];
                            r.byte_valid   = 1'b1;
                            r.last         = (i == n - 1);
                            r.bytes_read   = (i == n - 1) ? 7'(n) : 7'd0;
                            r.data_pending = frame_pending;
                            step_results.push_back(r);
                        end
                        tail_ptr = 10'((tl + n) % span);
                    end
                end
            end
        endcase
    endtask

    // Hold a request until it is taken, record its results, then maybe idle
    task automatic send_request(input req_t rq, input bit has_typed, input res_t typed);
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
        predict_ring_request(rq);
        if (has_typed)
        begin
            expected_results.push_back(typed);
        end
        else
        begin
            foreach (step_results[i])
            begin
                expected_results.push_back(step_results[i]);
            end
        end
        if (!steady && $urandom_range(0, 99) < 37)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // Send a request checked by the predictor; swap unsafe reads for a flush
    task automatic issue(input req_t rq);
        if (rq.req_type == REQ_READ && !read_is_safe(rq.max_len))
        begin
            rq.req_type = REQ_FLUSH;
        end
        send_request(rq, 1'b0, '0);
    endtask

    // Drop start, wait for every expected transaction, then let the block settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register, then hold off while the block reduces its pointers
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_config(idx, val);
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Read length: mostly short, sometimes zero, sometimes at or past the cap
    function automatic logic [6:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 7'd0;
        end
        if (r == 1)
        begin
            return 7'($urandom_range(64, 127));
        end
        return 7'($urandom_range(1, 16));
    endfunction

    // One frame: a burst of bytes, the idle event, then reads and maybe a flush
    task automatic run_frame();
        int   nbytes;
        int   nreads;
        int   k;
        req_t rq;
        nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 80) : $urandom_range(1, 12);
        for (k = 0; k < nbytes; k++)
        begin
            rq.req_type = REQ_BYTE;
            rq.rx_byte  = 8'($urandom);
            rq.max_len  = 7'($urandom);
            issue(rq);
        end
        rq.req_type = REQ_IDLE;
        issue(rq);
        nreads = $urandom_range(1, 3);
        for (k = 0; k < nreads; k++)
        begin
            rq.req_type = REQ_READ;
            rq.rx_byte  = 8'($urandom);
            rq.max_len  = pick_len();
            issue(rq);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            rq.req_type = REQ_FLUSH;
            issue(rq);
        end
    endtask

    function automatic plan_row_t req_row(input logic [1:0] kind, input logic [7:0] data,
                                          input logic [6:0] len);
        plan_row_t row;
        row = '0;
        row.rq.req_type = kind;
        row.rq.rx_byte  = data;
        row.rq.max_len  = len;
        return row;
    endfunction

    function automatic plan_row_t typed_row(input logic [1:0] kind, input logic [7:0] data,
                                            input logic [6:0] len, input logic status,
                                            input logic pend, input logic note);
        plan_row_t row;
        row = req_row(kind, data, len);
        row.has_typed          = 1'b1;
        row.typed.last         = 1'b1;
        row.typed.status       = status;
        row.typed.data_pending = pend;
        row.typed.notify       = note;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, result);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("out_byte", want.out_byte, result.out_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(result.byte_valid));
                check_field("last", 8'(want.last), 8'(result.last));
                check_field("status", 8'(want.status), 8'(result.status));
                check_field("bytes_read", 8'(want.bytes_read), 8'(result.bytes_read));
                check_field("data_pending", 8'(want.data_pending),
                            8'(result.data_pending));
                check_field("notify", 8'(want.notify), 8'(result.notify));
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("uart_dma_ring_receive_buffer regression: fail");
            $finish;
        end
    end

    initial
    begin
        int   p;
        int   phase_end;
        req_t rq;

        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        steady    = 1'b0;
        reset_shadow();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan: reset state, disabled input, a small ring with wrap,
        // length zero and saturation, whole-ring read, flush, then a one-byte ring
        directed_plan = '{
            typed_row(REQ_READ,  8'h00, 7'd5,   1'b1, 1'b0, 1'b0), // empty after reset
            req_row(REQ_BYTE,    8'hFF, 7'd0),                    // ignored, disabled
            req_row(REQ_IDLE,    8'h00, 7'd0),                    // ignored, disabled
            typed_row(REQ_FLUSH, 8'h00, 7'd0,   1'b0, 1'b0, 1'b0),
            reg_row(REG_BUFFER_SIZE, 11'd4),
            reg_row(REG_RECEIVE_ENABLE, 11'd1),
            req_row(REQ_BYTE,    8'h00, 7'd0),
            req_row(REQ_BYTE,    8'hFF, 7'd127),
            req_row(REQ_BYTE,    8'hA5, 7'd0),
            typed_row(REQ_IDLE,  8'h00, 7'd0,   1'b0, 1'b1, 1'b1),
            typed_row(REQ_READ,  8'h00, 7'd0,   1'b0, 1'b1, 1'b0), // length zero
            req_row(REQ_READ,    8'h00, 7'd2),
            req_row(REQ_READ,    8'h00, 7'd127),                  // length saturates
            typed_row(REQ_READ,  8'h00, 7'd1,   1'b1, 1'b0, 1'b0),
            req_row(REQ_BYTE,    8'h5A, 7'd0),                    // wraps write pointer
            typed_row(REQ_IDLE,  8'h00, 7'd0,   1'b0, 1'b1, 1'b1),
            req_row(REQ_BYTE,    8'h11, 7'd0),
            req_row(REQ_BYTE,    8'h22, 7'd0),
            req_row(REQ_BYTE,    8'h33, 7'd0),
            typed_row(REQ_IDLE,  8'h00, 7'd0,   1'b0, 1'b1, 1'b1), // head meets tail
            req_row(REQ_READ,    8'h00, 7'd64),                   // whole ring
            req_row(REQ_BYTE,    8'h77, 7'd0),
            typed_row(REQ_IDLE,  8'h00, 7'd0,   1'b0, 1'b1, 1'b1),
            typed_row(REQ_FLUSH, 8'h00, 7'd0,   1'b0, 1'b0, 1'b0),
            typed_row(REQ_READ,  8'h00, 7'd64,  1'b1, 1'b0, 1'b0),
            reg_row(REG_BUFFER_SIZE, 11'd0),                      // held to one byte
            req_row(REQ_BYTE,    8'h3C, 7'd0),
            typed_row(REQ_IDLE,  8'h00, 7'd0,   1'b0, 1'b1, 1'b1),
            req_row(REQ_READ,    8'h00, 7'd3)
        };

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_reg)
            begin
                drain();
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            end
            else
            begin
                send_request(directed_plan[i].rq, directed_plan[i].has_typed,
                             directed_plan[i].typed);
            end
        end

        // Random phases, one ring setting each; odd phases keep receive on
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            if (p % 2 == 0)
            begin
                write_reg(REG_RECEIVE_ENABLE, 11'd0);
            end
            write_reg(REG_BUFFER_SIZE, 11'(phase_size[p]));
            write_reg(REG_RECEIVE_ENABLE, 11'(phase_rx[p]));
            steady = (p == 3 || p == 4);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 99) < 75)
                begin
                    run_frame();
                end
                else
                begin
                    rq.req_type = 2'($urandom_range(0, 3));
                    rq.rx_byte  = 8'($urandom);
                    rq.max_len  = 7'($urandom);
                    issue(rq);
                end
            end
        end

        drain();
        $display("Covered %0d requests over %0d ring settings: %0d reads, %0d whole-ring reads,",
                 items_sent, PHASE_COUNT + 3, read_count, whole_ring_count);
        $display("%0d result transactions checked, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("uart_dma_ring_receive_buffer regression: pass");
        end
        else
        begin
            $display("uart_dma_ring_receive_buffer regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/udrrb_pkg.sv
sv/udrrb_ram.sv
sv/udrrb_ctrl.sv
sv/udrrb_dp.sv
sv/uart_dma_ring_receive_buffer.sv
dv/uart_dma_ring_receive_buffer_test.sv
